// ----- design/tcw_pkg.sv -----
// package for the text terminal character writer: item types and constants
package tcw_pkg;

  localparam int COLS_DEF     = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STEP_DEF = 4;

  localparam int CELL_W       = 16;
  localparam int CHAR_W       = 8;
  localparam int CURSOR_ROW_W = 5;
  localparam int CURSOR_COL_W = 7;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  localparam logic [CELL_W-1:0] RESET_CELL  = 16'h0720;
  localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h07;

  typedef struct packed {
    logic                    operation;
    logic [CHAR_W-1:0]       char_code;
    logic [CURSOR_ROW_W-1:0] read_row;
    logic [CURSOR_COL_W-1:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]       cell_value;
    logic [CURSOR_ROW_W-1:0] cursor_row;
    logic [CURSOR_COL_W-1:0] cursor_col;
  } out_item_t;

endpackage

// ----- design/text_terminal_char_writer.sv -----
// text terminal character writer: cell store, cursor and item sequencer
// results: put, tab, plain newline and out-of-range read give their result in the cycle after accept;
// backspace and in-range read pass through S_BS or S_READ first; a newline on the last row
// scrolls the screen (one cell copied per cycle over the single store port pair)
// reset: a clearing pass writes 0x0720 into all ROWS*COLS cells, busy meanwhile
// one item at a time, the next accepted in its result cycle; the receiver cannot stall
module text_terminal_char_writer
  import tcw_pkg::*;
#(
  parameter int COLS     = COLS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STEP = TAB_STEP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_valid,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [CHAR_W-1:0] cfg_wdata
);

  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int TAB_W  = COL_W + 5;

  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] LAST_A    = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((ROWS - 1) * COLS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLS - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_BS     = 3'd3;
  localparam logic [2:0] S_SCOPY  = 3'd4;
  localparam logic [2:0] S_SDRAIN = 3'd5;
  localparam logic [2:0] S_SBLANK = 3'd6;

  logic [CELL_W-1:0] screen_mem [CELLS];
  logic [CELL_W-1:0] mem_rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] wptr_r, wptr_nxt;
  logic              pend_r, pend_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0] out_cell_r, out_cell_nxt;
  logic [CHAR_W-1:0] text_color_r;

  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_in_range;
  logic [TAB_W-1:0]  tab_sum;
  logic [CELL_W-1:0] blank_cell;

  assign cur_addr    = ADDR_W'(row_r) * COLS_A + ADDR_W'(col_r);
  assign rd_addr     = ADDR_W'(in_item.read_row) * COLS_A + ADDR_W'(in_item.read_col);
  assign rd_in_range = (32'(in_item.read_row) < ROWS) && (32'(in_item.read_col) < COLS);
  assign tab_sum     = TAB_W'(col_r) + TAB_W'(TAB_STEP);
  assign blank_cell  = {text_color_r, CH_BLANK};

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = '{cell_value: out_cell_r,
                       cursor_row: CURSOR_ROW_W'(row_r),
                       cursor_col: CURSOR_COL_W'(col_r)};

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    wptr_nxt      = wptr_r;
    pend_nxt      = 1'b0;
    row_nxt       = row_r;
    col_nxt       = col_r;
    out_valid_nxt = 1'b0;
    out_cell_nxt  = out_cell_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_addr;
    mem_wdata     = blank_cell;
    mem_raddr     = rd_addr;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = RESET_CELL;
        if (ptr_r == LAST_A) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          out_cell_nxt = '0;
          if (in_item.operation == OP_READ) begin
            if (rd_in_range) begin
              state_nxt = S_READ;
            end else begin
              out_valid_nxt = 1'b1;
            end
          end else if (in_item.char_code inside {CH_LF, CH_CR}) begin
            col_nxt = '0;
            if (row_r == ROW_LAST) begin
              ptr_nxt   = '0;
              state_nxt = S_SCOPY;
            end else begin
              row_nxt       = row_r + 1'b1;
              out_valid_nxt = 1'b1;
            end
          end else if (in_item.char_code == CH_TAB) begin
            col_nxt       = (tab_sum > TAB_W'(COL_LAST)) ? COL_LAST : COL_W'(tab_sum);
            out_valid_nxt = 1'b1;
          end else if (in_item.char_code == CH_BS) begin
            mem_we    = 1'b1;
            col_nxt   = (col_r != '0) ? col_r - 1'b1 : col_r;
            state_nxt = S_BS;
          end else begin
            mem_we        = 1'b1;
            mem_wdata     = {text_color_r, in_item.char_code};
            out_valid_nxt = 1'b1;
            if (col_r == COL_LAST) begin
              col_nxt = '0;
              row_nxt = (row_r == ROW_LAST) ? '0 : row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_cell_nxt  = mem_rdata_r;
        state_nxt     = S_IDLE;
      end
      S_BS: begin
        mem_we        = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SCOPY: begin
        mem_raddr = ptr_r + COLS_A;
        pend_nxt  = 1'b1;
        wptr_nxt  = ptr_r;
        mem_we    = pend_r;
        mem_waddr = wptr_r;
        mem_wdata = mem_rdata_r;
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r == COPY_LAST) begin
          state_nxt = S_SDRAIN;
        end
      end
      S_SDRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = wptr_r;
        mem_wdata = mem_rdata_r;
        state_nxt = S_SBLANK;
      end
      S_SBLANK: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        if (ptr_r == LAST_A) begin
          ptr_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= screen_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      ptr_r        <= '0;
      pend_r       <= 1'b0;
      row_r        <= '0;
      col_r        <= '0;
      out_valid_r  <= 1'b0;
      text_color_r <= RESET_COLOR;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        text_color_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    wptr_r     <= wptr_nxt;
    out_cell_r <= out_cell_nxt;
  end

`ifndef SYNTH
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result strobe during clearing pass");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < ROWS) && (32'(col_r) < COLS))
    else $error("cursor outside the screen");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SBLANK) |-> (row_r == ROW_LAST) && (col_r == '0))
    else $error("cursor not at start of last row while scrolling");

  a_drain_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SDRAIN) |-> pend_r)
    else $error("scroll drain without a pending copy");
`endif

endmodule

// ----- verif/text_terminal_char_writer_checker.sv -----
`timescale 1ns / 1ps
// checker for the text terminal character writer: screen and cursor predictor, result compare
module text_terminal_char_writer_checker
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  in_item_t          in_item,
  input  logic              out_valid,
  input  out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [CHAR_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending
);

  localparam int NCELLS = COLS_DEF * ROWS_DEF;

  logic [CELL_W-1:0] screen [NCELLS];
  int                cur_row;
  int                cur_col;
  logic [CHAR_W-1:0] attr;
  out_item_t         expected_reports [$];

  function automatic out_item_t terminal_step(in_item_t it);
    out_item_t res;
    res = '0;
    if (it.operation == OP_PUT) begin
      case (it.char_code)
        CH_LF, CH_CR: begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= ROWS_DEF) begin
            for (int i = 0; i < NCELLS - COLS_DEF; i++) screen[i] = screen[i + COLS_DEF];
            for (int i = NCELLS - COLS_DEF; i < NCELLS; i++) screen[i] = {attr, CH_BLANK};
            cur_row = ROWS_DEF - 1;
          end
        end
        CH_TAB: begin
          cur_col = cur_col + TAB_STEP_DEF;
          if (cur_col > COLS_DEF - 1) cur_col = COLS_DEF - 1;
        end
        CH_BS: begin
          screen[cur_row * COLS_DEF + cur_col] = {attr, CH_BLANK};
          if (cur_col > 0) cur_col--;
          screen[cur_row * COLS_DEF + cur_col] = {attr, CH_BLANK};
        end
        default: begin
          screen[cur_row * COLS_DEF + cur_col] = {attr, it.char_code};
          cur_col++;
          if (cur_col >= COLS_DEF) begin
            cur_col = 0;
            cur_row++;
            // wrap to the top, no scroll
            if (cur_row >= ROWS_DEF) cur_row = 0;
          end
        end
      endcase
    end else if (it.read_row < ROWS_DEF && it.read_col < COLS_DEF) begin
      res.cell_value = screen[it.read_row * COLS_DEF + it.read_col];
    end
    res.cursor_row = CURSOR_ROW_W'(cur_row);
    res.cursor_col = CURSOR_COL_W'(cur_col);
    return res;
  endfunction

  function automatic void report_field(string field, logic [CELL_W-1:0] exp_v,
                                       logic [CELL_W-1:0] act_v);
    $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
    fail_count++;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < NCELLS; i++) screen[i] = RESET_CELL;
      cur_row    = 0;
      cur_col    = 0;
      attr       = RESET_COLOR;
      fail_count = 0;
      expected_reports.delete();
    end else begin
      if (out_valid) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_item);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (out_item.cell_value !== want.cell_value)
            report_field("cell_value", want.cell_value, out_item.cell_value);
          if (out_item.cursor_row !== want.cursor_row)
            report_field("cursor_row", CELL_W'(want.cursor_row), CELL_W'(out_item.cursor_row));
          if (out_item.cursor_col !== want.cursor_col)
            report_field("cursor_col", CELL_W'(want.cursor_col), CELL_W'(out_item.cursor_col));
        end
      end
      if (cfg_we) attr = cfg_wdata;
      if (start && !busy) expected_reports.push_back(terminal_step(in_item));
    end
    pending = expected_reports.size();
  end

endmodule

// ----- verif/text_terminal_char_writer_tb.sv -----
`timescale 1ns / 1ps
// testbench top for the text terminal character writer: clock, reset, item and color stimulus
module text_terminal_char_writer_tb;
  import tcw_pkg::*;

  localparam int PHASE_ITEMS = 240;
  localparam int NUM_PHASES  = 6;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_item;
  logic              out_valid;
  out_item_t         out_item;
  logic              cfg_we;
  logic [CHAR_W-1:0] cfg_wdata;

  int                fail_count;
  int                pending;
  int                issued;
  int                burst_left;
  logic [CURSOR_ROW_W-1:0] last_row;

  text_terminal_char_writer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  text_terminal_char_writer_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // cursor row of the latest result, used to aim reads at fresh text
  always @(posedge clk) begin
    if (!rst_n) begin
      last_row <= '0;
    end else if (out_valid) begin
      last_row <= out_item.cursor_row;
    end
  end

  initial begin
    #150_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic in_item_t noise_item();
    in_item_t it;
    it.operation = 1'($urandom);
    it.char_code = CHAR_W'($urandom);
    it.read_row  = CURSOR_ROW_W'($urandom);
    it.read_col  = CURSOR_COL_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t put_item(logic [CHAR_W-1:0] ch);
    in_item_t it;
    it = noise_item();
    it.operation = OP_PUT;
    it.char_code = ch;
    return it;
  endfunction

  function automatic in_item_t read_item(int row, int col);
    in_item_t it;
    it = noise_item();
    it.operation = OP_READ;
    it.read_row  = CURSOR_ROW_W'(row);
    it.read_col  = CURSOR_COL_W'(col);
    return it;
  endfunction

  function automatic logic [CHAR_W-1:0] newline_char();
    return ($urandom_range(0, 1) == 1) ? CH_LF : CH_CR;
  endfunction

  task automatic issue(input in_item_t it);
    start   = 1'b1;
    in_item = it;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    issued++;
    burst_left--;
    if (burst_left <= 0) begin
      start = 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8))
        @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_sequence();
    int kind;
    int row;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // a line of text, often long enough to wrap
      repeat ($urandom_range(1, 90))
        issue(put_item(($urandom_range(0, 9) == 0) ? CHAR_W'($urandom)
                                                    : CHAR_W'($urandom_range(33, 126))));
      if ($urandom_range(0, 9) < 7) issue(put_item(newline_char()));
    end else if (kind < 45) begin
      repeat ($urandom_range(1, 22)) issue(put_item(CH_TAB));
    end else if (kind < 55) begin
      repeat ($urandom_range(0, 4)) issue(put_item(CHAR_W'($urandom_range(33, 126))));
      repeat ($urandom_range(1, 8)) issue(put_item(CH_BS));
    end else if (kind < 75) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 9) < 7) begin
          row = int'(last_row) - int'($urandom_range(0, 1));
          issue(read_item((row < 0) ? 0 : row, $urandom_range(0, COLS_DEF - 1)));
        end else begin
          issue(read_item($urandom_range(0, 31), $urandom_range(0, 127)));
        end
      end
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 5)) issue(put_item(newline_char()));
    end else begin
      repeat ($urandom_range(1, 6)) issue(noise_item());
    end
  endtask

  initial begin
    int phase_end;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    issued     = 0;
    burst_left = $urandom_range(1, 40);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);
    while (busy) @(negedge clk);

    // directed items with the reset color
    issue(read_item(0, 0));
    issue(read_item(ROWS_DEF - 1, COLS_DEF - 1));
    issue(read_item(ROWS_DEF, 0));
    issue(read_item(0, COLS_DEF));
    issue(read_item(31, 127));
    issue(put_item(8'h00));
    issue(put_item(8'hFF));
    issue(put_item(8'h41));
    issue(read_item(0, 0));
    issue(read_item(0, 2));
    repeat (4) issue(put_item(CH_BS));
    issue(read_item(0, 0));
    issue(read_item(0, 1));
    issue(put_item(CH_TAB));
    issue(put_item(CH_TAB));
    issue(put_item(CH_CR));
    issue(put_item(CH_LF));
    issue(put_item(8'h7E));
    issue(read_item(2, 0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      cfg_we    = 1'b1;
      cfg_wdata = (ph == 0) ? 8'hFF : (ph == 1) ? 8'h00 : CHAR_W'($urandom);
      @(negedge clk);
      cfg_we = 1'b0;
      phase_end = issued + PHASE_ITEMS;
      while (issued < phase_end) random_sequence();
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/tcw_pkg.sv
design/text_terminal_char_writer.sv
verif/text_terminal_char_writer_checker.sv
verif/text_terminal_char_writer_tb.sv
